// ----- rtl/core/fbba_pkg.sv -----
`timescale 1ns / 1ps

package fbba_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WORD_BYTES = 8;
    localparam int SCAN_W     = 10;   // holds the word count of the largest map in use
    localparam int MAP_W      = 12;

    localparam logic [MAP_W-1:0] BYTES_CAP = 12'd4092;
    localparam logic [7:0] FIRST_BYTE = 8'h1F;
    localparam logic [7:0] FULL_BYTE  = 8'hFF;

    // byte 0 sits in the low bits of word 0
    localparam logic [WORD_BITS-1:0] FIRST_WORD = {{(WORD_BYTES - 1){FULL_BYTE}}, FIRST_BYTE};
    localparam logic [WORD_BITS-1:0] FULL_WORD  = {WORD_BYTES{FULL_BYTE}};

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_INIT  = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_SCAN,
        S_ALLOC_WR,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] pos;      // bit index inside the 64-bit word
        logic [5:0] offset;   // block offset inside the word, msb of byte 0 first
    } find_t;

endpackage

// ----- rtl/core/fbba_if.sv -----
`timescale 1ns / 1ps

interface fbba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] block;

    modport source (output valid, output func, output block, input ready);
    modport sink (input valid, input func, input block, output ready);
endinterface

interface fbba_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] allocated_block;
    logic [1:0]  status;

    modport source (output valid, output allocated_block, output status, input ready);
    modport sink (input valid, input allocated_block, input status, output ready);
endinterface

// ----- rtl/core/free_block_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// allocate: one 64-bit map word read per cycle
//   through the single read port of the map memory, scan pipelined behind the read
// free: read, modify-write, result; out-of-range free and unused codes go straight to the result
// init: refill of every map word, one word written per cycle
// one request at a time; the next request is taken once the current one's result is in the response register
// reset: map_bytes clears, then a refill pass over every map word, ready low
module free_block_bitmap_allocator
#(
    parameter int MAP_DEPTH = 4096
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fbba_pkg::MAP_W-1:0]    cfg_wdata,
    fbba_req_if.sink                      req,
    fbba_rsp_if.source                    rsp
);

    localparam int WORDS = (MAP_DEPTH + fbba_pkg::WORD_BYTES - 1) / fbba_pkg::WORD_BYTES;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LIMIT = (MAP_DEPTH < 4092) ? MAP_DEPTH : 4092;

    logic [fbba_pkg::WORD_BITS-1:0] map_mem [WORDS];

    fbba_pkg::state_t state_reg, state_next;
    logic [fbba_pkg::MAP_W-1:0]     map_bytes_reg;
    logic [fbba_pkg::SCAN_W-1:0]    issue_ptr_reg, issue_ptr_next;
    logic [fbba_pkg::SCAN_W-1:0]    chk_ptr_reg, chk_ptr_next;
    logic                           chk_valid_reg, chk_valid_next;
    logic [WAW-1:0]                 fill_ptr_reg, fill_ptr_next;
    logic                           init_item_reg, init_item_next;
    logic [WAW-1:0]                 word_addr_reg, word_addr_next;
    logic [fbba_pkg::WORD_BITS-1:0] word_reg, word_next;
    logic [5:0]                     pos_reg, pos_next;
    logic [15:0]                    granted_reg, granted_next;
    logic [1:0]                     status_reg, status_next;
    logic                           out_valid_reg, out_valid_next;
    logic [15:0]                    out_block_reg, out_block_next;
    logic [1:0]                     out_status_reg, out_status_next;
    logic [fbba_pkg::WORD_BITS-1:0] rd_data_reg;

    logic                           rd_en;
    logic [WAW-1:0]                 rd_addr;
    logic                           wr_en;
    logic [WAW-1:0]                 wr_addr;
    logic [fbba_pkg::WORD_BITS-1:0] wr_data;

    logic [fbba_pkg::MAP_W-1:0]     n_bytes;
    logic [fbba_pkg::SCAN_W-1:0]    n_words;
    logic [15:0]                    blk_m1;
    logic                           blk_bad;
    fbba_pkg::find_t                find;

    assign n_bytes = (map_bytes_reg > fbba_pkg::MAP_W'(LIMIT))
                   ? fbba_pkg::MAP_W'(LIMIT) : map_bytes_reg;
    assign n_words = fbba_pkg::SCAN_W'((13'(n_bytes) + 13'd7) >> 3);
    assign blk_m1  = req.block - 16'd1;
    assign blk_bad = (req.block == 16'd0) || (req.block > {1'b0, n_bytes, 3'b000});

    fbba_find u_find
    (
        .word      (rd_data_reg),
        .base_byte ({chk_ptr_reg, 3'b000}),
        .n_bytes   (n_bytes),
        .res       (find)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbba_pkg::S_FILL;
            map_bytes_reg <= '0;
            issue_ptr_reg <= '0;
            chk_ptr_reg   <= '0;
            chk_valid_reg <= 1'b0;
            fill_ptr_reg  <= '0;
            init_item_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_ptr_reg <= issue_ptr_next;
            chk_ptr_reg   <= chk_ptr_next;
            chk_valid_reg <= chk_valid_next;
            fill_ptr_reg  <= fill_ptr_next;
            init_item_reg <= init_item_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                map_bytes_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_addr_reg  <= word_addr_next;
        word_reg       <= word_next;
        pos_reg        <= pos_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
        out_block_reg  <= out_block_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_ptr_next  = issue_ptr_reg;
        chk_ptr_next    = chk_ptr_reg;
        chk_valid_next  = 1'b0;
        fill_ptr_next   = fill_ptr_reg;
        init_item_next  = init_item_reg;
        word_addr_next  = word_addr_reg;
        word_next       = word_reg;
        pos_next        = pos_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_block_next  = out_block_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        rd_addr         = word_addr_reg;
        wr_en           = 1'b0;
        wr_addr         = word_addr_reg;
        wr_data         = word_reg;

        unique case (state_reg)
            fbba_pkg::S_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = fill_ptr_reg;
                wr_data = (fill_ptr_reg == '0) ? fbba_pkg::FIRST_WORD : fbba_pkg::FULL_WORD;
                fill_ptr_next = fill_ptr_reg + 1'b1;
                if (fill_ptr_reg == WAW'(WORDS - 1))
                begin
                    fill_ptr_next  = '0;
                    init_item_next = 1'b0;
                    state_next     = init_item_reg ? fbba_pkg::S_DONE : fbba_pkg::S_IDLE;
                end
            end

            fbba_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    granted_next = 16'd0;
                    status_next  = fbba_pkg::STATUS_DONE;
                    unique case (req.func)
                        fbba_pkg::FUNC_ALLOC:
                        begin
                            issue_ptr_next = '0;
                            state_next     = fbba_pkg::S_SCAN;
                        end
                        fbba_pkg::FUNC_FREE:
                        begin
                            if (blk_bad)
                            begin
                                status_next = fbba_pkg::STATUS_RANGE;
                                state_next  = fbba_pkg::S_DONE;
                            end
                            else
                            begin
                                word_addr_next = WAW'(blk_m1 >> 6);
                                pos_next       = {blk_m1[5:3], ~blk_m1[2:0]};
                                state_next     = fbba_pkg::S_FREE_RD;
                            end
                        end
                        fbba_pkg::FUNC_INIT:
                        begin
                            fill_ptr_next  = '0;
                            init_item_next = 1'b1;
                            state_next     = fbba_pkg::S_FILL;
                        end
                        default:
                        begin
                            state_next = fbba_pkg::S_DONE;
                        end
                    endcase
                end
            end

            fbba_pkg::S_SCAN:
            begin
                // reads stream one word ahead of the check
                rd_addr = WAW'(issue_ptr_reg);
                if (issue_ptr_reg < n_words)
                begin
                    rd_en          = 1'b1;
                    issue_ptr_next = issue_ptr_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_ptr_next   = issue_ptr_reg;
                end
                if (chk_valid_reg && find.hit)
                begin
                    chk_valid_next = 1'b0;
                    word_addr_next = WAW'(chk_ptr_reg);
                    word_next      = rd_data_reg;
                    pos_next       = find.pos;
                    granted_next   = 16'({chk_ptr_reg, 6'b000000}) + 16'(find.offset) + 16'd1;
                    status_next    = fbba_pkg::STATUS_DONE;
                    state_next     = fbba_pkg::S_ALLOC_WR;
                end
                else if (!chk_valid_reg && !(issue_ptr_reg < n_words))
                begin
                    // every word in use checked, nothing free
                    granted_next = 16'd0;
                    status_next  = fbba_pkg::STATUS_FULL;
                    state_next   = fbba_pkg::S_DONE;
                end
            end

            fbba_pkg::S_ALLOC_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = word_reg & ~(64'd1 << pos_reg);
                state_next = fbba_pkg::S_DONE;
            end

            fbba_pkg::S_FREE_RD:
            begin
                rd_en      = 1'b1;
                state_next = fbba_pkg::S_FREE_WR;
            end

            fbba_pkg::S_FREE_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data_reg | (64'd1 << pos_reg);
                state_next = fbba_pkg::S_DONE;
            end

            fbba_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_block_next  = granted_reg;
                    out_status_next = status_reg;
                    state_next      = fbba_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fbba_pkg::S_IDLE;
            end
        endcase
    end

    assign req.ready           = (state_reg == fbba_pkg::S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.allocated_block = out_block_reg;
    assign rsp.status          = out_status_reg;

endmodule

// ----- rtl/core/fbba_find.sv -----
`timescale 1ns / 1ps

module fbba_find
(
    input  logic [fbba_pkg::WORD_BITS-1:0] word,
    input  logic [12:0]                    base_byte,
    input  logic [fbba_pkg::MAP_W-1:0]     n_bytes,
    output fbba_pkg::find_t                res
);

    logic [7:0] masked [fbba_pkg::WORD_BYTES];
    logic [7:0] sel_byte;
    logic [2:0] sel_j;
    logic [2:0] sel_b;
    logic       hit;
    logic       bhit;

    always_comb
    begin
        hit   = 1'b0;
        sel_j = 3'd0;
        for (int j = 0; j < fbba_pkg::WORD_BYTES; j++)
        begin
            // bytes past the map in use never match
            if ((base_byte + 13'(j)) < {1'b0, n_bytes})
            begin
                masked[j] = word[8*j +: 8];
            end
            else
            begin
                masked[j] = 8'd0;
            end
            if (!hit && masked[j] != 8'd0)
            begin
                hit   = 1'b1;
                sel_j = 3'(j);
            end
        end

        sel_byte = masked[sel_j];
        bhit     = 1'b0;
        sel_b    = 3'd0;
        for (int b = 0; b < 8; b++)
        begin
            if (!bhit && sel_byte[7-b])
            begin
                bhit  = 1'b1;
                sel_b = 3'(b);
            end
        end

        res.hit    = hit;
        res.offset = {sel_j, sel_b};
        res.pos    = {sel_j, ~sel_b};
    end

endmodule
